/* hdl/qrm_pkg.sv */
// ----------------------------------------------------------------------------
// qrm_pkg
// shared constants for the quaternion to rotation matrix pipeline
// ----------------------------------------------------------------------------
package qrm_pkg;

    localparam int IN_WIDTH_DEF      = 16;
    localparam int OUT_FRAC_BITS_DEF = 14;
    localparam int NUM_ELEMS         = 9;

    // product slots
    localparam int P_XX = 0;
    localparam int P_YY = 1;
    localparam int P_ZZ = 2;
    localparam int P_WW = 3;
    localparam int P_XY = 4;
    localparam int P_XZ = 5;
    localparam int P_YZ = 6;
    localparam int P_WX = 7;
    localparam int P_WY = 8;
    localparam int P_WZ = 9;
    localparam int NUM_PRODS = 10;

endpackage

/* hdl/quaternion_to_rotation_matrix.sv */
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix
// normalized quaternion to 3x3 rotation matrix, fully pipelined
// ----------------------------------------------------------------------------
// channel  dir  tdata                                   tuser
// s_       in   quat_x, quat_y, quat_z, quat_w          -
// m_       out  elem_r0c0 .. elem_r2c2 (column major)   zero_length
//
// one quaternion per cycle while m_tready does not stall the pipeline
// the restoring divider yields one quotient bit per stage
// aresetn clears the valid bits only
// a stall on m_tready freezes the whole pipeline, nothing is lost or repeated
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix #(
    parameter int IN_WIDTH      = qrm_pkg::IN_WIDTH_DEF,
    parameter int OUT_FRAC_BITS = qrm_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // quat_x, quat_y, quat_z, quat_w
    input  logic [((4*IN_WIDTH+7)/8)*8-1:0]      s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // elem_r0c0, r1c0, r2c0, r0c1, r1c1, r2c1, r0c2, r1c2, r2c2
    output logic [((qrm_pkg::NUM_ELEMS*(OUT_FRAC_BITS+2)+7)/8)*8-1:0] m_tdata,
    // zero_length
    output logic                                 m_tuser
);
    import qrm_pkg::*;

    localparam int W   = IN_WIDTH;
    localparam int OW  = OUT_FRAC_BITS + 2;
    localparam int PW  = 2 * W;
    localparam int NW  = 2 * W + 2;
    localparam int SW  = 2 * W + 3;
    localparam int D   = OUT_FRAC_BITS + 2;
    localparam int ODW = ((NUM_ELEMS * OW + 7) / 8) * 8;

    logic ce;
    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    // stage 1: magnitudes and signs
    logic [W-1:0] mag_reg [0:3];
    logic [3:0]   sgn_reg;
    logic         v1_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 4; i++) begin
                sgn_reg[i] <= s_tdata[i*W+W-1];
                mag_reg[i] <= s_tdata[i*W+W-1] ? W'(-s_tdata[i*W +: W]) : s_tdata[i*W +: W];
            end
        end
    end

    // stage 2: products
    logic [PW-1:0] prod_reg [0:NUM_PRODS-1];
    logic [NUM_PRODS-1:0] psgn_reg;
    logic [1:0] pa [0:NUM_PRODS-1];
    logic [1:0] pb [0:NUM_PRODS-1];
    logic       v2_reg;
    logic [PW+W-1:0] den_sum;

    always_comb begin
        pa[P_XX] = 2'd0; pb[P_XX] = 2'd0;
        pa[P_YY] = 2'd1; pb[P_YY] = 2'd1;
        pa[P_ZZ] = 2'd2; pb[P_ZZ] = 2'd2;
        pa[P_WW] = 2'd3; pb[P_WW] = 2'd3;
        pa[P_XY] = 2'd0; pb[P_XY] = 2'd1;
        pa[P_XZ] = 2'd0; pb[P_XZ] = 2'd2;
        pa[P_YZ] = 2'd1; pb[P_YZ] = 2'd2;
        pa[P_WX] = 2'd3; pb[P_WX] = 2'd0;
        pa[P_WY] = 2'd3; pb[P_WY] = 2'd1;
        pa[P_WZ] = 2'd3; pb[P_WZ] = 2'd2;
        den_sum  = '0;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int p = 0; p < NUM_PRODS; p++) begin
                prod_reg[p] <= PW'(mag_reg[pa[p]]) * PW'(mag_reg[pb[p]]);
                psgn_reg[p] <= sgn_reg[pa[p]] ^ sgn_reg[pb[p]];
            end
        end
    end

    // stage 3: signed numerators and denominator
    logic signed [SW-1:0] sp [0:NUM_PRODS-1];
    logic signed [SW-1:0] num_next [0:NUM_ELEMS-1];
    logic signed [SW-1:0] num_reg  [0:NUM_ELEMS-1];
    logic [NW-1:0] den3_next;
    logic [NW-1:0] den3_reg;
    logic v3_reg;

    always_comb begin
        for (int p = 0; p < NUM_PRODS; p++) begin
            sp[p] = psgn_reg[p] ? -$signed(SW'(prod_reg[p])) : $signed(SW'(prod_reg[p]));
        end
        num_next[0] = sp[P_WW] + sp[P_XX] - sp[P_YY] - sp[P_ZZ];
        num_next[1] = (sp[P_XY] + sp[P_WZ]) <<< 1;
        num_next[2] = (sp[P_XZ] - sp[P_WY]) <<< 1;
        num_next[3] = (sp[P_XY] - sp[P_WZ]) <<< 1;
        num_next[4] = sp[P_WW] + sp[P_YY] - sp[P_XX] - sp[P_ZZ];
        num_next[5] = (sp[P_YZ] + sp[P_WX]) <<< 1;
        num_next[6] = (sp[P_XZ] + sp[P_WY]) <<< 1;
        num_next[7] = (sp[P_YZ] - sp[P_WX]) <<< 1;
        num_next[8] = sp[P_WW] + sp[P_ZZ] - sp[P_XX] - sp[P_YY];
        den3_next = NW'(prod_reg[P_XX]) + NW'(prod_reg[P_YY]) + NW'(prod_reg[P_ZZ])
                  + NW'(prod_reg[P_WW]) + NW'(den_sum);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            num_reg  <= num_next;
            den3_reg <= den3_next;
        end
    end

    // divider pipeline, index 0 holds the magnitudes
    logic [NW-1:0] rem_reg [0:D][0:NUM_ELEMS-1];
    logic [OW-1:0] quo_reg [0:D][0:NUM_ELEMS-1];
    logic [NUM_ELEMS-1:0] esgn_reg [0:D];
    logic [NW-1:0] den_reg [0:D];
    logic [D:0]    dv_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int e = 0; e < NUM_ELEMS; e++) begin
                esgn_reg[0][e] <= num_reg[e][SW-1];
                rem_reg[0][e]  <= num_reg[e][SW-1] ? NW'(-num_reg[e]) : NW'(num_reg[e]);
                quo_reg[0][e]  <= '0;
            end
            den_reg[0] <= den3_reg;
        end
    end

    for (genvar k = 1; k <= D; k++) begin : g_div
        logic [NW-1:0] rem_next [0:NUM_ELEMS-1];
        logic [OW-1:0] quo_next [0:NUM_ELEMS-1];
        logic [NW-1:0] sh;

        always_comb begin
            sh = '0;
            for (int e = 0; e < NUM_ELEMS; e++) begin
                sh = (k == 1) ? rem_reg[k-1][e] : {rem_reg[k-1][e][NW-2:0], 1'b0};
                if (sh >= den_reg[k-1]) begin
                    rem_next[e] = sh - den_reg[k-1];
                    quo_next[e] = {quo_reg[k-1][e][OW-2:0], 1'b1};
                end else begin
                    rem_next[e] = sh;
                    quo_next[e] = {quo_reg[k-1][e][OW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[k]  <= rem_next;
                quo_reg[k]  <= quo_next;
                esgn_reg[k] <= esgn_reg[k-1];
                den_reg[k]  <= den_reg[k-1];
            end
        end
    end

    // rounding, sign and zero-length override
    localparam logic [OW-1:0] ONE = OW'(1) << OUT_FRAC_BITS;
    logic [ODW-1:0] out_next;
    logic [OW:0]    rnd;
    logic [OW-1:0]  mag_out;
    logic           zl;

    always_comb begin
        out_next = '0;
        rnd      = '0;
        mag_out  = '0;
        zl       = (den_reg[D] == '0);
        for (int e = 0; e < NUM_ELEMS; e++) begin
            rnd     = ({1'b0, quo_reg[D][e]} + (OW+1)'(1)) >> 1;
            mag_out = (rnd > (OW+1)'(ONE)) ? ONE : rnd[OW-1:0];
            if (zl) begin
                out_next[e*OW +: OW] = (e == 0 || e == 4 || e == 8) ? ONE : '0;
            end else begin
                out_next[e*OW +: OW] = esgn_reg[D][e] ? OW'(-mag_out) : mag_out;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            m_tdata <= out_next;
            m_tuser <= zl;
        end
    end

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            dv_reg   <= '0;
            m_tvalid <= 1'b0;
        end else if (ce) begin
            v1_reg   <= s_tvalid;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            dv_reg   <= {dv_reg[D-1:0], v3_reg};
            m_tvalid <= dv_reg[D];
        end
    end

endmodule

/* test/quaternion_to_rotation_matrix_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_tb
// drives quaternions through the stream input with random gaps and stalls,
// predicts each rotation matrix with exact integer division and compares
// every matrix entry and the zero-length flag in transfer order
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix_tb;

    localparam int IW    = qrm_pkg::IN_WIDTH_DEF;
    localparam int FB    = qrm_pkg::OUT_FRAC_BITS_DEF;
    localparam int EW    = FB + 2;
    localparam int NE    = qrm_pkg::NUM_ELEMS;
    localparam int SW    = ((4*IW+7)/8)*8;
    localparam int MW    = ((NE*EW+7)/8)*8;
    localparam int LAT   = FB + 7;
    localparam int ONE   = 1 << FB;

    typedef logic signed [IW-1:0] comp_t;
    typedef struct packed {
        comp_t w, z, y, x;
    } quat_t;
    typedef struct {
        logic [EW-1:0] elem [NE];
        logic          zero_len;
    } matrix_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [SW-1:0] s_tdata = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [MW-1:0] m_tdata;
    logic          m_tuser;

    quat_t   pending_quats [$];
    matrix_t expected_matrices [$];
    bit      failed = 1'b0;
    bit      stim_done = 1'b0;
    int      send_gap = 0;
    int      stall_left = 0;
    logic    s_tready_q = 1'b0;

    quaternion_to_rotation_matrix i_dut (.*);

    initial begin
        forever #1 aclk = ~aclk;
    end

    // rounded num * 2^FB / den, ties away from zero, saturated at one
    function automatic longint unsigned scaled_ratio(longint unsigned num,
                                                    longint unsigned den);
        longint unsigned q;
        q = ((num << (FB + 1)) / den + 1) >> 1;
        return (q > ONE) ? ONE : q;
    endfunction

    function automatic matrix_t rotation_of(quat_t q);
        matrix_t m;
        longint signed x, y, z, w, den, num [NE];
        longint unsigned r;
        x = q.x; y = q.y; z = q.z; w = q.w;
        den = x*x + y*y + z*z + w*w;
        m.zero_len = (den == 0);
        num[0] = w*w + x*x - y*y - z*z;
        num[1] = 2*(x*y + w*z);
        num[2] = 2*(x*z - w*y);
        num[3] = 2*(x*y - w*z);
        num[4] = w*w + y*y - x*x - z*z;
        num[5] = 2*(y*z + w*x);
        num[6] = 2*(x*z + w*y);
        num[7] = 2*(y*z - w*x);
        num[8] = w*w + z*z - x*x - y*y;
        for (int i = 0; i < NE; i++) begin
            if (den == 0) begin
                m.elem[i] = (i % 4 == 0) ? EW'(ONE) : '0;
            end else if (num[i] < 0) begin
                r = scaled_ratio(-num[i], den);
                m.elem[i] = EW'(-longint'(r));
            end else begin
                r = scaled_ratio(num[i], den);
                m.elem[i] = EW'(r);
            end
        end
        return m;
    endfunction

    function automatic comp_t rand_comp();
        case ($urandom_range(0, 5))
            0: return comp_t'(16'sh8000);
            1: return comp_t'(16'sh7fff);
            2: return comp_t'($urandom_range(0, 8) - 4);
            3: return comp_t'(0);
            default: return comp_t'($urandom);
        endcase
    endfunction

    initial begin
        quat_t q;
        comp_t ext [6];
        ext = '{comp_t'(0), comp_t'(1), comp_t'(-1), comp_t'(16'sh7fff),
                comp_t'(16'sh8000), comp_t'(8192)};
        pending_quats.push_back('{w: 0, z: 0, y: 0, x: 0});
        for (int i = 0; i < 6; i++) begin
            pending_quats.push_back('{w: ext[i], z: 0, y: 0, x: ext[(i+1)%6]});
            pending_quats.push_back('{w: ext[(i+3)%6], z: ext[i], y: ext[(i+2)%6],
                                      x: ext[(i+4)%6]});
        end
        pending_quats.push_back('{w: 16'sh8000, z: 16'sh8000, y: 16'sh8000, x: 16'sh8000});
        pending_quats.push_back('{w: 16'sh7fff, z: 16'sh7fff, y: 16'sh7fff, x: 16'sh7fff});
        pending_quats.push_back('{w: 0, z: 1, y: 1, x: 0});
        pending_quats.push_back('{w: 1, z: 1, y: 1, x: 0});
        pending_quats.push_back('{w: 0, z: 0, y: 3, x: 0});
        pending_quats.push_back('{w: 16'sh5555, z: 16'shaaaa, y: 16'sh5555, x: 16'shaaaa});
        for (int i = 0; i < 550; i++) begin
            q.x = rand_comp(); q.y = rand_comp(); q.z = rand_comp(); q.w = rand_comp();
            pending_quats.push_back(q);
        end
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        wait (pending_quats.size() == 0 && !s_tvalid);
        wait (expected_matrices.size() == 0);
        repeat (LAT + 5) @(posedge aclk);
        stim_done = 1'b1;
    end

    // driver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_tready_q) begin
                if (send_gap > 0) begin
                    s_tvalid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (pending_quats.size() > 0) begin
                    s_tdata  <= SW'(pending_quats.pop_front());
                    s_tvalid <= 1'b1;
                    send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            if (stall_left > 0) begin
                m_tready   <= 1'b0;
                stall_left <= stall_left - 1;
            end else begin
                m_tready   <= 1'b1;
                stall_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
            end
        end
    end

    // transfer flag sampled at the rising edge, read by the driver
    always @(posedge aclk) begin
        s_tready_q <= s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready)
            expected_matrices.push_back(rotation_of(quat_t'(s_tdata[4*IW-1:0])));
    end

    // monitor
    always @(posedge aclk) begin
        matrix_t exp_m;
        logic [EW-1:0] got;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_matrices.size() == 0) begin
                $display("%0t: unexpected transfer, tdata %h", $time, m_tdata);
                failed = 1'b1;
            end else begin
                exp_m = expected_matrices.pop_front();
                for (int i = 0; i < NE; i++) begin
                    got = m_tdata[i*EW +: EW];
                    if (got !== exp_m.elem[i]) begin
                        $display("%0t: elem %0d expected %h actual %h", $time, i,
                                 exp_m.elem[i], got);
                        failed = 1'b1;
                    end
                end
                if (m_tuser !== exp_m.zero_len) begin
                    $display("%0t: zero_length expected %b actual %b", $time,
                             exp_m.zero_len, m_tuser);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        wait (stim_done);
        if (!failed)
            $display("quaternion_to_rotation_matrix test passed");
        else
            $display("quaternion_to_rotation_matrix test failed");
        $finish;
    end

    initial begin
        #200000;
        $display("quaternion_to_rotation_matrix test failed");
        $finish;
    end

endmodule
